// ----- hdl/psf_pkg.sv -----
// Shared constants, sequencer states and helpers for the scanline polygon fill.
// Used by psf_div and polygon_scanline_fill.
package psf_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int COORD_BITS_DEF   = 10;
  localparam int FRAC_BITS_DEF    = 16;

  localparam int PADDR_W          = 2;
  localparam int REG_W            = 11;
  localparam logic [REG_W-1:0] ROW_COUNT_RST = 11'd32;
  localparam logic [PADDR_W-1:0] ADDR_ROW_COUNT = 2'd0;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_FILL = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_B_SETUP,
    ST_B_EDGE,
    ST_B_NDY,
    ST_B_CHK,
    ST_B_DIV,
    ST_F_INS,
    ST_F_POS,
    ST_F_SPAN,
    ST_F_ADV,
    ST_F_SORT,
    ST_F_SCMP
  } state_t;

endpackage

// ----- hdl/polygon_scanline_fill.sv -----
// Top level of the scanline polygon fill: vertex/edge stores, active list and sequencer.
// Depends on psf_pkg and psf_div.
//
// A load item stores one vertex. The item that closes the polygon then builds the edge table
// with busy high: each side whose y increases searches forward for the next vertex on a
// different row, and each non-horizontal side that starts within the row range, while the
// table has room, gets a slope division in the shared divider before its edge is stored.
// A fill item inserts the pending edges that start on the current row into the active list
// in x order, emits the spans of the row, advances each active edge by its slope or drops it
// once finished, and insertion-sorts the list. Results appear on strobe for exactly one cycle
// each and cannot be stalled; the last result of an item has last_span set. Beyond the final
// row every fill item returns a single invalid result with rows_done set.
module polygon_scanline_fill
  import psf_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  start,
  output logic                  busy,
  input  logic                  command,
  input  logic [9:0]            vertex_x,
  input  logic [9:0]            vertex_y,
  input  logic                  last_vertex,
  output logic                  strobe,
  output logic [9:0]            row,
  output logic [9:0]            span_start,
  output logic [10:0]           span_end,
  output logic                  span_valid,
  output logic                  last_span,
  output logic                  rows_done
);

  localparam int C   = COORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int IW  = $clog2(MAX_VERTICES);
  localparam int NW  = $clog2(MAX_VERTICES + 1);
  localparam int QW  = C + F + 1;
  localparam int XW  = C + F + 2;
  localparam int EW  = (C + 1 > REG_W) ? C + 1 : REG_W;
  localparam logic [EW-1:0] ROWS_MAX = EW'(1) << C;
  localparam logic [C-1:0]  CMASK    = {C{1'b1}};

  // Configuration register
  logic [REG_W-1:0] row_count;
  logic [EW-1:0]    rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= ROW_COUNT_RST;
    end else if (psel && penable && pwrite && paddr == ADDR_ROW_COUNT) begin
      row_count <= pwdata[REG_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = 32'(row_count);

  always_comb begin
    if (row_count == '0) rows = EW'(1);
    else if (EW'(row_count) > ROWS_MAX) rows = ROWS_MAX;
    else rows = EW'(row_count);
  end

  // Stores
  logic [C-1:0]          vx [MAX_VERTICES];
  logic [C-1:0]          vy [MAX_VERTICES];
  logic [C-1:0]          e_start [MAX_VERTICES];
  logic [C-1:0]          e_top [MAX_VERTICES];
  logic signed [XW-1:0]  e_x [MAX_VERTICES];
  logic signed [XW-1:0]  e_dx [MAX_VERTICES];
  logic [IW-1:0]         order [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] pending;

  logic [NW-1:0] vtot, bn, etot, atot, i, j, t, p, k, kept;
  logic [IW-1:0] v1, lo, hi, idx;
  logic [C-1:0]  yprev, comp, rowc;
  logic          finished, dn, neg;
  logic          have;
  logic [C-1:0]  hs;
  logic [C:0]    he;
  state_t        state, state_next;

  assign busy = (state != ST_IDLE);

  // Divider hookup
  logic             dgo, ddone;
  logic [QW-1:0]    dvd, quot;
  logic [C-1:0]     den;
  logic signed [C:0] ddiff;
  logic [C-1:0]     mag;

  always_comb begin
    den   = vy[hi] - vy[lo];
    ddiff = $signed({1'b0, vx[hi]}) - $signed({1'b0, vx[lo]});
    mag   = ddiff[C] ? C'(-ddiff) : ddiff[C-1:0];
    dvd   = {1'b0, mag, {F{1'b0}}} + QW'(den >> 1);
  end

  psf_div #(.NUM_W(QW), .DEN_W(C)) u_div (
    .clk(clk), .rst(rst), .go(dgo), .dividend(dvd), .divisor(den),
    .done(ddone), .quot(quot)
  );

  // Span of the current pair
  logic signed [XW-1:0] x1, x2;
  logic signed [XW:0]   x2c;
  logic [XW-F-1:0]      fl;
  logic [XW-F:0]        ce;
  logic [C-1:0]         sv;
  logic [C:0]           ev;

  always_comb begin
    x1  = e_x[order[p[IW-1:0]]];
    x2  = e_x[order[IW'(p + 1'b1)]];
    x2c = XW'(x2) + $signed((XW+1)'((1 << F) - 1));
    fl  = x1[XW-1:F];
    ce  = x2c[XW:F];
    if (x1 <= 0) sv = '0;
    else if (fl > (XW-F)'(CMASK)) sv = CMASK;
    else sv = fl[C-1:0];
    if (x2 <= 0) ev = '0;
    else if (ce > (XW-F+1)'(ROWS_MAX)) ev = (C+1)'(ROWS_MAX);
    else ev = ce[C:0];
  end

  // Next-state logic
  always_comb begin
    state_next = state;
    dgo        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start && command == CMD_LOAD && last_vertex) state_next = ST_B_SETUP;
        else if (start && command == CMD_FILL && !finished && EW'(rowc) < rows)
          state_next = ST_F_INS;
      end
      ST_B_SETUP: state_next = (bn < NW'(2)) ? ST_IDLE : ST_B_EDGE;
      ST_B_EDGE: begin
        if (i == bn) state_next = ST_IDLE;
        else if (vy[v1] < vy[i[IW-1:0]]) state_next = ST_B_NDY;
        else if (vy[v1] > vy[i[IW-1:0]]) state_next = ST_B_CHK;
      end
      ST_B_NDY: begin
        if (!(t < bn && vy[i[IW-1:0]] == vy[j[IW-1:0]])) state_next = ST_B_CHK;
      end
      ST_B_CHK: begin
        if (EW'(vy[lo]) >= rows || etot >= NW'(MAX_VERTICES)) begin
          state_next = ST_B_EDGE;
        end else begin
          dgo        = 1'b1;
          state_next = ST_B_DIV;
        end
      end
      ST_B_DIV: if (ddone) state_next = ST_B_EDGE;
      ST_F_INS: begin
        if (i == etot) state_next = ST_F_SPAN;
        else if (pending[i[IW-1:0]] && e_start[i[IW-1:0]] == rowc &&
                 atot < NW'(MAX_VERTICES)) state_next = ST_F_POS;
      end
      ST_F_POS: begin
        if (!(p < atot && !(e_x[i[IW-1:0]] < e_x[order[p[IW-1:0]]])))
          state_next = ST_F_INS;
      end
      ST_F_SPAN: if (!(NW'(p + 1'b1) < atot)) state_next = ST_F_ADV;
      ST_F_ADV: if (!(p < atot)) state_next = ST_F_SORT;
      ST_F_SORT: state_next = (p < atot) ? ST_F_SCMP : ST_IDLE;
      ST_F_SCMP: begin
        if (!(k != '0 && e_x[idx] < e_x[order[IW'(k - 1'b1)]])) state_next = ST_F_SORT;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Datapath and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vtot     <= '0;
      etot     <= '0;
      atot     <= '0;
      pending  <= '0;
      rowc     <= '0;
      finished <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start && command == CMD_LOAD) begin
            // Store the vertex, then close the polygon if asked
            if (vtot < NW'(MAX_VERTICES)) begin
              vx[vtot[IW-1:0]] <= vertex_x[C-1:0];
              vy[vtot[IW-1:0]] <= vertex_y[C-1:0];
            end
            if (last_vertex) begin
              bn       <= (vtot < NW'(MAX_VERTICES)) ? NW'(vtot + 1'b1) : vtot;
              vtot     <= '0;
              etot     <= '0;
              pending  <= '0;
              atot     <= '0;
              rowc     <= '0;
              finished <= 1'b0;
            end else if (vtot < NW'(MAX_VERTICES)) begin
              vtot <= vtot + 1'b1;
            end
          end else if (start) begin
            if (finished || EW'(rowc) >= rows) begin
              strobe     <= 1'b1;
              row        <= 10'(rowc);
              span_start <= '0;
              span_end   <= '0;
              span_valid <= 1'b0;
              last_span  <= 1'b1;
              rows_done  <= 1'b1;
            end else begin
              dn <= (EW'(rowc) + 1'b1 >= rows);
              i  <= '0;
            end
          end
        end
        ST_B_SETUP: begin
          yprev <= vy[IW'(bn - 2'd2)];
          v1    <= IW'(bn - 1'b1);
          i     <= '0;
        end
        ST_B_EDGE: begin
          if (i != bn) begin
            if (vy[v1] < vy[i[IW-1:0]]) begin
              lo <= v1;
              hi <= i[IW-1:0];
              j  <= (NW'(i + 1'b1) >= bn) ? '0 : NW'(i + 1'b1);
              t  <= '0;
            end else if (vy[v1] > vy[i[IW-1:0]]) begin
              lo   <= i[IW-1:0];
              hi   <= v1;
              comp <= yprev;
            end else begin
              yprev <= vy[v1];
              v1    <= i[IW-1:0];
              i     <= i + 1'b1;
            end
          end
        end
        ST_B_NDY: begin
          // Walk forward to the next vertex on a different row
          if (t < bn && vy[i[IW-1:0]] == vy[j[IW-1:0]]) begin
            j <= (NW'(j + 1'b1) >= bn) ? '0 : NW'(j + 1'b1);
            t <= t + 1'b1;
          end else begin
            comp <= vy[j[IW-1:0]];
          end
        end
        ST_B_CHK: begin
          neg <= ddiff[C];
          if (EW'(vy[lo]) >= rows || etot >= NW'(MAX_VERTICES)) begin
            yprev <= vy[v1];
            v1    <= i[IW-1:0];
            i     <= i + 1'b1;
          end
        end
        ST_B_DIV: begin
          if (ddone) begin
            e_dx[etot[IW-1:0]]    <= neg ? -$signed(XW'(quot)) : $signed(XW'(quot));
            e_x[etot[IW-1:0]]     <= $signed(XW'({vx[lo], {F{1'b0}}}));
            e_start[etot[IW-1:0]] <= vy[lo];
            e_top[etot[IW-1:0]]   <= (vy[hi] < comp) ? C'(vy[hi] - 1'b1) : vy[hi];
            pending[etot[IW-1:0]] <= 1'b1;
            etot  <= etot + 1'b1;
            yprev <= vy[v1];
            v1    <= i[IW-1:0];
            i     <= i + 1'b1;
          end
        end
        ST_F_INS: begin
          if (i == etot) begin
            p    <= '0;
            have <= 1'b0;
          end else if (pending[i[IW-1:0]] && e_start[i[IW-1:0]] == rowc) begin
            pending[i[IW-1:0]] <= 1'b0;
            if (atot < NW'(MAX_VERTICES)) p <= '0;
            else i <= i + 1'b1;
          end else begin
            i <= i + 1'b1;
          end
        end
        ST_F_POS: begin
          // Find the slot, then open it and drop the edge in
          if (p < atot && !(e_x[i[IW-1:0]] < e_x[order[p[IW-1:0]]])) begin
            p <= p + 1'b1;
          end else begin
            for (int n = 1; n < MAX_VERTICES; n++) begin
              if (NW'(n) > p && NW'(n) <= atot) order[n] <= order[n-1];
            end
            order[p[IW-1:0]] <= i[IW-1:0];
            atot <= atot + 1'b1;
            i    <= i + 1'b1;
          end
        end
        ST_F_SPAN: begin
          // Hold each span back one step so the final one can carry last_span
          if (NW'(p + 1'b1) < atot) begin
            if (ev > {1'b0, sv}) begin
              if (have) begin
                strobe     <= 1'b1;
                row        <= 10'(rowc);
                span_start <= 10'(hs);
                span_end   <= 11'(he);
                span_valid <= 1'b1;
                last_span  <= 1'b0;
                rows_done  <= dn;
              end
              have <= 1'b1;
              hs   <= sv;
              he   <= ev;
            end
            p <= NW'(p + 2'd2);
          end else begin
            strobe     <= 1'b1;
            row        <= 10'(rowc);
            span_start <= have ? 10'(hs) : '0;
            span_end   <= have ? 11'(he) : '0;
            span_valid <= have;
            last_span  <= 1'b1;
            rows_done  <= dn;
            p          <= '0;
            kept       <= '0;
          end
        end
        ST_F_ADV: begin
          // Drop finished edges, step the rest by their slope
          if (p < atot) begin
            if (rowc < e_top[order[p[IW-1:0]]]) begin
              e_x[order[p[IW-1:0]]] <= e_x[order[p[IW-1:0]]] + e_dx[order[p[IW-1:0]]];
              order[kept[IW-1:0]]   <= order[p[IW-1:0]];
              kept <= kept + 1'b1;
            end
            p <= p + 1'b1;
          end else begin
            atot <= kept;
            p    <= NW'(1);
          end
        end
        ST_F_SORT: begin
          if (p < atot) begin
            idx <= order[p[IW-1:0]];
            k   <= p;
          end else if (dn) begin
            finished <= 1'b1;
          end else begin
            rowc <= rowc + 1'b1;
          end
        end
        ST_F_SCMP: begin
          if (k != '0 && e_x[idx] < e_x[order[IW'(k - 1'b1)]]) begin
            order[k[IW-1:0]] <= order[IW'(k - 1'b1)];
            k <= k - 1'b1;
          end else begin
            order[k[IW-1:0]] <= idx;
            p <= p + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/psf_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on psf_pkg (imported for house consistency of widths).
module psf_div
  import psf_pkg::*;
#(
  parameter int NUM_W = 27,
  parameter int DEN_W = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] dvd;
  logic [DEN_W-1:0] dsr;
  logic [DEN_W:0]   trial;
  logic             qbit;

  // Shift in one dividend bit and try the subtract
  always_comb begin
    trial = {rem, dvd[NUM_W-1]};
    qbit  = (trial >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dvd  <= dividend;
        dsr  <= divisor;
      end else if (busy) begin
        rem <= qbit ? DEN_W'(trial - {1'b0, dsr}) : trial[DEN_W-1:0];
        dvd <= {dvd[NUM_W-2:0], qbit};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = dvd;

endmodule
